// ===== sv/rme_pkg.sv =====
package rme_pkg;

    // Fixed-point set-up of the angle pipeline.
    localparam int CORDIC_STEPS     = 16;
    localparam int MATRIX_FRAC_BITS = 14;

    // Operand and accumulator widths of the vectoring unit.
    localparam int OPND_W  = 17;
    localparam int CXY_W   = 36;
    localparam int CZ_W    = 34;
    localparam int ANG_W   = 17;
    localparam int ATAN_W  = 31;

    // Square-root unit: one result bit per stage.
    localparam int ISQ_STEPS = MATRIX_FRAC_BITS + 1;
    localparam int RAD_W     = 2 * MATRIX_FRAC_BITS + 1;
    localparam int SQ_W      = 32;
    localparam logic [SQ_W:0] MAT_ONE = (SQ_W + 1)'(1) << (2 * MATRIX_FRAC_BITS);

    localparam logic signed [CZ_W-1:0]  ANG_PI_Q30  = CZ_W'(64'd3373259426);
    localparam logic signed [ANG_W-1:0] OUT_PI      = ANG_W'(25736);
    localparam logic signed [ANG_W-1:0] OUT_HALF_PI = ANG_W'(12868);
    localparam logic [14:0]             LIMIT_RESET = 15'd16384;

    typedef enum logic [1:0] {
        CASE_NORMAL = 2'd0,
        CASE_MINUS  = 2'd1,
        CASE_PLUS   = 2'd2
    } case_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r22;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        case_t              code;
    } pose_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [ATAN_W-1:0] atan_q30(input int i);
        logic [ATAN_W-1:0] a;
        case (i)
            0:  a = 31'd843314857;
            1:  a = 31'd497837829;
            2:  a = 31'd263043837;
            3:  a = 31'd133525159;
            4:  a = 31'd67021687;
            5:  a = 31'd33543516;
            6:  a = 31'd16775851;
            7:  a = 31'd8388437;
            8:  a = 31'd4194283;
            9:  a = 31'd2097149;
            10: a = 31'd1048575;
            11: a = 31'd524287;
            12: a = 31'd262143;
            13: a = 31'd131071;
            14: a = 31'd65535;
            15: a = 31'd32767;
            16: a = 31'd16383;
            17: a = 31'd8191;
            18: a = 31'd4095;
            19: a = 31'd2047;
            20: a = 31'd1023;
            21: a = 31'd511;
            22: a = 31'd255;
            23: a = 31'd127;
            24: a = 31'd63;
            25: a = 31'd31;
            26: a = 31'd15;
            27: a = 31'd8;
            28: a = 31'd4;
            29: a = 31'd2;
            30: a = 31'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Saturate an angle to plus or minus a limit.
    function automatic logic signed [ANG_W-1:0] clamp_ang(input logic signed [ANG_W-1:0] v,
                                                          input logic signed [ANG_W-1:0] lim);
        logic signed [ANG_W-1:0] r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== sv/rme_isqrt.sv =====
module rme_isqrt
    import rme_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  pose_t            in_pose,
    input  logic [RAD_W-1:0] in_rad,
    output logic             out_vld,
    output pose_t            out_pose,
    output logic [RAD_W-1:0] out_root
);

    logic             vld_reg  [ISQ_STEPS];
    pose_t            pose_reg [ISQ_STEPS];
    logic [RAD_W-1:0] v_reg    [ISQ_STEPS];
    logic [RAD_W-1:0] r_reg    [ISQ_STEPS];

    // One restoring step per stage, from the top bit pair down.
    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ISQ_STEPS - 1 - k));
        logic             vld_in;
        pose_t            pose_in;
        logic [RAD_W-1:0] v_in;
        logic [RAD_W-1:0] r_in;
        logic [RAD_W-1:0] trial;
        logic [RAD_W-1:0] v_next;
        logic [RAD_W-1:0] r_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_vld;
            assign pose_in = in_pose;
            assign v_in    = in_rad;
            assign r_in    = '0;
        end
        else begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign pose_in = pose_reg[k-1];
            assign v_in    = v_reg[k-1];
            assign r_in    = r_reg[k-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            if (v_in >= trial)
            begin
                v_next = v_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pose_reg[k] <= pose_in;
                v_reg[k]    <= v_next;
                r_reg[k]    <= r_next;
            end
        end
    end

    assign out_vld  = vld_reg[ISQ_STEPS-1];
    assign out_pose = pose_reg[ISQ_STEPS-1];
    assign out_root = r_reg[ISQ_STEPS-1];

endmodule

// ===== sv/rme_cordic.sv =====
module rme_cordic
    import rme_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [OPND_W-1:0] x_in,
    input  logic signed [OPND_W-1:0] y_in,
    output logic signed [ANG_W-1:0]  ang
);

    logic signed [CXY_W-1:0] x_reg    [CORDIC_STEPS+1];
    logic signed [CXY_W-1:0] y_reg    [CORDIC_STEPS+1];
    logic signed [CZ_W-1:0]  z_reg    [CORDIC_STEPS+1];
    logic                    zero_reg [CORDIC_STEPS+1];

    logic signed [CXY_W-1:0] x_ext;
    logic signed [CXY_W-1:0] y_ext;
    logic signed [CZ_W-1:0]  z_end;

    // Scale the operands up and fold the left half-plane onto the right.
    assign x_ext = {{(CXY_W-OPND_W-16){x_in[OPND_W-1]}}, x_in, 16'b0};
    assign y_ext = {{(CXY_W-OPND_W-16){y_in[OPND_W-1]}}, y_in, 16'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -x_ext;
                y_reg[0] <= -y_ext;
                z_reg[0] <= (y_in >= 0) ? ANG_PI_Q30 : -ANG_PI_Q30;
            end
            else
            begin
                x_reg[0] <= x_ext;
                y_reg[0] <= y_ext;
                z_reg[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage towards the x axis.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        localparam logic signed [CZ_W-1:0] ATAN = CZ_W'(atan_q30(i));
        logic signed [CXY_W-1:0] xs;
        logic signed [CXY_W-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
            end
        end
    end

    // Round Q30 radians to radians times 8192.
    assign z_end = z_reg[CORDIC_STEPS] + CZ_W'(65536);
    assign ang   = zero_reg[CORDIC_STEPS] ? '0 : ANG_W'(z_end >>> 17);

endmodule

// ===== sv/rotation_matrix_to_euler_angles.sv =====
// Converts one rigid pose per beat into x-y-z Tait-Bryan angles (roll, pitch, yaw in
// radians times 8192) and passes the translation through unchanged. The block is fully
// pipelined and accepts a pose every clock cycle unless the result is held back; a pose
// passes through the input, square stage and radicand register, one square-root bit per
// stage, the prepare stage and CORDIC_STEPS vectoring stages, and the output register.
// Back-pressure on the result stalls the whole pipeline. case_code on m_tuser says which
// path ran: normal, or gimbal lock with pitch at minus or plus half pi, where yaw is
// zero. gimbal_limit is to be written on the cfg channel only while the block is idle;
// the block itself does not enforce this.
module rotation_matrix_to_euler_angles
    import rme_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // Pose beats.
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [207:0]  s_tdata,   // r00, r01, r02, r10, r11, r12, r22, tx_in, ty_in, tz_in
    // Result beats.
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata,   // tx_out, ty_out, tz_out, roll, pitch, yaw, zero pad
    output logic [1:0]    m_tuser,   // case_code
    // Configuration.
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [14:0]   cfg_data   // gimbal_limit
);

    localparam int DLY = CORDIC_STEPS + 1;

    logic        en;
    logic [14:0] limit_reg;

    logic        s0_vld_reg;
    pose_t       s0_pose_reg;
    logic        s1_vld_reg;
    pose_t       s1_pose_reg;
    pose_t       s1_pose_next;
    logic [SQ_W-1:0] s1_sq_reg;
    logic        s2_vld_reg;
    pose_t       s2_pose_reg;
    logic [RAD_W-1:0] s2_rad_reg;

    logic             sq_vld;
    pose_t            sq_pose;
    logic [RAD_W-1:0] sq_root;

    logic  dly_vld_reg  [DLY];
    pose_t dly_pose_reg [DLY];

    logic signed [OPND_W-1:0] roll_x, roll_y, yaw_x, yaw_y, asin_x, asin_y;
    logic signed [ANG_W-1:0]  roll_ang, yaw_ang, pitch_ang;

    logic signed [16:0]  r02_ext;
    logic signed [16:0]  lim_ext;
    case_t               code_next;

    pose_t               pe;
    logic signed [ANG_W-1:0] roll_c, pitch_c;
    logic signed [15:0]  roll_next, yaw_next;
    logic signed [14:0]  pitch_next;

    logic                out_vld_reg;
    logic [143:0]        out_data_reg;
    logic [1:0]          out_user_reg;

    // The whole pipeline moves when the output register can take a beat.
    assign en        = !out_vld_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    // Path decision: the plus side is checked first.
    assign r02_ext = {s0_pose_reg.r02[15], s0_pose_reg.r02};
    assign lim_ext = {2'b00, limit_reg};
    always_comb
    begin
        if (r02_ext >= lim_ext)
            code_next = CASE_PLUS;
        else if (r02_ext <= -lim_ext)
            code_next = CASE_MINUS;
        else
            code_next = CASE_NORMAL;
        s1_pose_next      = s0_pose_reg;
        s1_pose_next.code = code_next;
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= s_tvalid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Unpack, square the sine, then form the radicand one minus sine squared.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_pose_reg.r00  <= s_tdata[15:0];
            s0_pose_reg.r01  <= s_tdata[31:16];
            s0_pose_reg.r02  <= s_tdata[47:32];
            s0_pose_reg.r10  <= s_tdata[63:48];
            s0_pose_reg.r11  <= s_tdata[79:64];
            s0_pose_reg.r12  <= s_tdata[95:80];
            s0_pose_reg.r22  <= s_tdata[111:96];
            s0_pose_reg.tx   <= s_tdata[143:112];
            s0_pose_reg.ty   <= s_tdata[175:144];
            s0_pose_reg.tz   <= s_tdata[207:176];
            s0_pose_reg.code <= CASE_NORMAL;

            s1_pose_reg      <= s1_pose_next;
            s1_sq_reg        <= SQ_W'(s0_pose_reg.r02 * s0_pose_reg.r02);

            s2_pose_reg <= s1_pose_reg;
            if ({1'b0, s1_sq_reg} >= MAT_ONE)
                s2_rad_reg <= '0;
            else
                s2_rad_reg <= RAD_W'(MAT_ONE - {1'b0, s1_sq_reg});
        end
    end

    rme_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .in_pose  (s2_pose_reg),
        .in_rad   (s2_rad_reg),
        .out_vld  (sq_vld),
        .out_pose (sq_pose),
        .out_root (sq_root)
    );

    // Operands of the three vectoring units.
    always_comb
    begin
        if (sq_pose.code == CASE_NORMAL)
        begin
            roll_x = OPND_W'(sq_pose.r22);
            roll_y = -OPND_W'(sq_pose.r12);
        end
        else
        begin
            roll_x = OPND_W'(sq_pose.r11);
            roll_y = OPND_W'(sq_pose.r10);
        end
        yaw_x  = OPND_W'(sq_pose.r00);
        yaw_y  = -OPND_W'(sq_pose.r01);
        asin_x = OPND_W'(sq_root);
        asin_y = OPND_W'(sq_pose.r02);
    end

    rme_cordic u_roll (
        .clk  (clk),
        .en   (en),
        .x_in (roll_x),
        .y_in (roll_y),
        .ang  (roll_ang)
    );

    rme_cordic u_yaw (
        .clk  (clk),
        .en   (en),
        .x_in (yaw_x),
        .y_in (yaw_y),
        .ang  (yaw_ang)
    );

    rme_cordic u_pitch (
        .clk  (clk),
        .en   (en),
        .x_in (asin_x),
        .y_in (asin_y),
        .ang  (pitch_ang)
    );

    // Pose and valid travel alongside the vectoring units.
    for (genvar d = 0; d < DLY; d++) begin : g_dly
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dly_vld_reg[d] <= 1'b0;
            else if (en)
                dly_vld_reg[d] <= (d == 0) ? sq_vld : dly_vld_reg[(d == 0) ? 0 : d-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dly_pose_reg[d] <= (d == 0) ? sq_pose : dly_pose_reg[(d == 0) ? 0 : d-1];
        end
    end

    // Select the angles for the path taken and saturate them.
    assign pe      = dly_pose_reg[DLY-1];
    assign roll_c  = clamp_ang(roll_ang, OUT_PI);
    assign pitch_c = clamp_ang(pitch_ang, OUT_HALF_PI);
    always_comb
    begin
        case (pe.code)
            CASE_PLUS:
            begin
                roll_next  = 16'(roll_c);
                pitch_next = 15'(OUT_HALF_PI);
                yaw_next   = '0;
            end
            CASE_MINUS:
            begin
                roll_next  = 16'(-roll_c);
                pitch_next = 15'(-OUT_HALF_PI);
                yaw_next   = '0;
            end
            default:
            begin
                roll_next  = 16'(roll_c);
                pitch_next = 15'(pitch_c);
                yaw_next   = 16'(clamp_ang(yaw_ang, OUT_PI));
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dly_vld_reg[DLY-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {1'b0, yaw_next, pitch_next, roll_next, pe.tz, pe.ty, pe.tx};
            out_user_reg <= pe.code;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Gimbal-lock results carry zero yaw.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == CASE_PLUS || m_tuser == CASE_MINUS) |-> m_tdata[142:127] == '0)
        else $error("yaw not zero under gimbal lock");

    // Plus-side lock reports pitch of plus half pi.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == CASE_PLUS |-> $signed(m_tdata[126:112]) == 15'sd12868)
        else $error("pitch wrong on plus-side lock");

    // Pitch never leaves plus or minus half pi.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[126:112]) <= 15'sd12868
                  && $signed(m_tdata[126:112]) >= -15'sd12868)
        else $error("pitch out of range");

    // A held result keeps its case code and its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tuser) && $stable(m_tdata))
        else $error("held result changed");

endmodule

// ===== tb/sv/tb_rotation_matrix_to_euler_angles.sv =====
`timescale 1ns / 100ps

module tb_rotation_matrix_to_euler_angles;
    import rme_pkg::*;

    localparam int LATENCY    = MATRIX_FRAC_BITS + CORDIC_STEPS + 6;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 450;

    // One expected result beat.
    typedef struct {
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tz;
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [15:0] yaw;
        case_t       code;
    } euler_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [14:0]  cfg_data;

    logic [207:0] pose_queue[$];
    euler_t       euler_queue[$];
    logic [14:0]  limit_now;
    int           error_count;
    int           idle_cycles;
    bit           hold_off;
    bit           src_paused;
    bit           took_beat;
    int           gap_left;
    int           burst_left;
    int           stall_phase;

    rotation_matrix_to_euler_angles uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Floor division by a power of two on a signed value.
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(input longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring arctangent, Q30 radians.
    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint xs;
        longint ys;
        if (x == 0 && y == 0)
            return 0;
        z = 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_q30(i));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_q30(i));
            end
        end
        return z;
    endfunction

    function automatic longint scale_angle(input longint z, input longint lim);
        longint v;
        v = shr_floor(z + 65536, 17);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    function automatic euler_t pose_to_euler(input logic [207:0] d, input logic [14:0] lim);
        euler_t e;
        longint r00, r01, r02, r10, r11, r12, r22, sq, c, lm, rl, pt, yw;
        r00 = longint'($signed(d[15:0]));
        r01 = longint'($signed(d[31:16]));
        r02 = longint'($signed(d[47:32]));
        r10 = longint'($signed(d[63:48]));
        r11 = longint'($signed(d[79:64]));
        r12 = longint'($signed(d[95:80]));
        r22 = longint'($signed(d[111:96]));
        lm  = longint'(lim);
        e.tx = d[143:112];
        e.ty = d[175:144];
        e.tz = d[207:176];
        if (r02 >= lm)
        begin
            e.code = CASE_PLUS;
            pt = 12868;
            yw = 0;
            rl = scale_angle(vector_angle(r10, r11), 25736);
        end
        else if (r02 <= -lm)
        begin
            e.code = CASE_MINUS;
            pt = -12868;
            yw = 0;
            rl = -scale_angle(vector_angle(r10, r11), 25736);
        end
        else
        begin
            e.code = CASE_NORMAL;
            sq = r02 * r02;
            c = (sq >= (longint'(1) << 28)) ? 0 : root_floor((longint'(1) << 28) - sq);
            pt = scale_angle(vector_angle(r02, c), 12868);
            rl = scale_angle(vector_angle(-r12, r22), 25736);
            yw = scale_angle(vector_angle(-r01, r00), 25736);
        end
        e.roll  = rl[15:0];
        e.pitch = pt[14:0];
        e.yaw   = yw[15:0];
        return e;
    endfunction

    function automatic logic [15:0] rand_elem();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'(16384);
        if (k == 1)
            return 16'(-16384);
        if (k == 2)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [207:0] rand_pose(input bit near_lock);
        logic [207:0] d;
        for (int i = 0; i < 7; i++)
            d[i*16 +: 16] = rand_elem();
        if (near_lock)
            d[47:32] = 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(15000, 16384)));
        for (int i = 0; i < 3; i++)
            d[112 + i*32 +: 32] = $urandom;
        return d;
    endfunction

    function automatic logic [207:0] make_pose(input int a, input int b, input int c,
                                               input int e, input int f, input int g,
                                               input int h);
        logic [207:0] d;
        d = '0;
        d[15:0] = 16'(a);
        d[31:16] = 16'(b);
        d[47:32] = 16'(c);
        d[63:48] = 16'(e);
        d[79:64] = 16'(f);
        d[95:80] = 16'(g);
        d[111:96] = 16'(h);
        d[143:112] = $urandom;
        d[175:144] = 32'h8000_0000;
        d[207:176] = 32'h7fff_ffff;
        return d;
    endfunction

    // Append a pose to the list of pending input beats.
    task automatic queue_pose(input logic [207:0] d);
        pose_queue.insert(pose_queue.size(), d);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic wait_drained();
        while (pose_queue.size() != 0 || euler_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [14:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limit_now = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Directed corners then random poses, in phases over several limits.
    initial
    begin
        logic [14:0] limits[5];
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        hold_off  = 1'b0;
        src_paused = 1'b0;
        error_count = 0;
        limit_now = LIMIT_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Corners with the reset limit: lock at both ends, zero operands, negative x.
        queue_pose(make_pose(16384, 0, 0, 0, 16384, 0, 16384));
        queue_pose(make_pose(0, 0, 16384, 8000, 8000, 0, 0));
        queue_pose(make_pose(0, 0, -16384, -8000, 8000, 0, 0));
        queue_pose(make_pose(0, 0, 16384, 0, 0, 0, 0));
        queue_pose(make_pose(-16384, 0, 5000, 0, 0, 0, -16384));
        queue_pose(make_pose(-16384, 16384, -5000, 0, 0, -16384, -16384));
        queue_pose(make_pose(0, 0, 16383, 0, 0, 0, 0));
        queue_pose(make_pose(-1, -1, -16383, -16384, -1, 16384, 1));
        queue_pose(make_pose(0, -16384, 0, 0, -16384, 16384, 0));
        queue_pose(make_pose(16384, 16384, 1, 16384, 16384, -16384, -16384));
        queue_pose(make_pose(32767, -32768, 0, -32768, 32767, 32767, -32768));
        wait_drained();

        // Zero limit: r02 of zero takes the plus side.
        write_limit(15'd0);
        queue_pose(make_pose(100, 200, 0, 300, 400, 500, 600));
        queue_pose(make_pose(100, 200, -1, 300, 400, 500, 600));
        wait_drained();

        // Largest limit: sine beyond one on the normal path, and full-scale sine on both lock sides.
        write_limit(15'h7fff);
        queue_pose(make_pose(0, 0, 20000, 10, 10, 10, 10));
        queue_pose(make_pose(0, 0, -32768, 10, 10, 10, 10));
        queue_pose(make_pose(0, 0, 32767, 10, 10, 10, 10));
        wait_drained();

        limits[0] = 15'd16000;
        limits[1] = 15'd1;
        limits[2] = 15'h7fff;
        limits[3] = 15'($urandom_range(0, 16384));
        limits[4] = LIMIT_RESET;
        for (int p = 0; p < 5; p++)
        begin
            write_limit(limits[p]);
            for (int n = 0; n < N_RANDOM / 5; n++)
                queue_pose(rand_pose($urandom_range(0, 3) == 0));
            // Long receiver hold-off while poses keep coming.
            if (p == 1)
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Sender: bursts with gaps; a beat is held until the last rising edge took it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || took_beat)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pose_queue.size() != 0 && !cfg_valid)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pose_queue[0];
                    if (burst_left <= 0)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern.
    always @(negedge clk)
    begin
        if (!rst_n)
            stall_phase <= 0;
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_off)
                m_tready <= 1'b0;
            else if ((stall_phase / 64) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: record accepted poses, check accepted results, watch for a hang.
    always @(posedge clk)
    begin
        euler_t e;
        bit     moved;
        if (rst_n)
        begin
            moved = 1'b0;
            took_beat <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                euler_queue.insert(euler_queue.size(), pose_to_euler(s_tdata, limit_now));
                void'(pose_queue.pop_front());
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                if (euler_queue.size() == 0)
                begin
                    $display("unexpected result beat");
                    error_count++;
                end
                else
                begin
                    e = euler_queue.pop_front();
                    if (m_tdata[31:0] !== e.tx)
                        report("tx", m_tdata[31:0], e.tx);
                    if (m_tdata[63:32] !== e.ty)
                        report("ty", m_tdata[63:32], e.ty);
                    if (m_tdata[95:64] !== e.tz)
                        report("tz", m_tdata[95:64], e.tz);
                    if (m_tdata[111:96] !== e.roll)
                        report("roll", m_tdata[111:96], e.roll);
                    if (m_tdata[126:112] !== e.pitch)
                        report("pitch", m_tdata[126:112], e.pitch);
                    if (m_tdata[142:127] !== e.yaw)
                        report("yaw", m_tdata[142:127], e.yaw);
                    if (m_tuser !== e.code)
                        report("case_code", m_tuser, e.code);
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
        else
        begin
            idle_cycles <= 0;
            took_beat   <= 1'b0;
        end
    end

    initial
    begin
        gap_left = 0;
        burst_left = 0;
        idle_cycles = 0;
        took_beat = 1'b0;
    end

endmodule
